// ===== rtl/core/frmn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frmn_pkg
// Shared widths and types for the fraction reduction block.
// ----------------------------------------------------------------------------
package frmn_pkg;

    localparam int DataWidth = 32;
    localparam int MagWidth  = DataWidth;
    localparam int CntWidth  = $clog2(MagWidth + 1);

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_ZERO_DEN = 1'b1;

    typedef logic [DataWidth-1:0] data_t;
    typedef logic [MagWidth-1:0]  mag_t;

endpackage

// ===== rtl/core/fraction_reduce_mixed_number.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reduce_mixed_number
// Reduces a signed fraction to lowest terms and returns it as a mixed number.
// ----------------------------------------------------------------------------
//  channel | dir | ports
//  s_      | in  | s_valid s_ready s_numer_in s_denom_in
//  m_      | out | m_valid m_ready m_status m_is_negative m_whole_part
//          |     | m_frac_numer m_frac_denom
//
// Each item runs one division per Euclid step plus three more divisions
// (reduced numerator, reduced denominator, whole part) on a shared restoring
// divider that retires one quotient bit per cycle.
// A zero denominator skips the divisions and goes straight to DONE.
// s_ready is high only in IDLE; a waiting result holds until m_ready.
// Reset is synchronous and active low and clears control state only.
// ----------------------------------------------------------------------------
module fraction_reduce_mixed_number (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  frmn_pkg::data_t        s_numer_in,
    input  frmn_pkg::data_t        s_denom_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_status,
    output logic                   m_is_negative,
    output logic [31:0]            m_whole_part,
    output logic [30:0]            m_frac_numer,
    output logic [31:0]            m_frac_denom
);
    import frmn_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GCD_START, ST_GCD_DIV, ST_GCD_STEP,
        ST_RN_START, ST_RN_DIV, ST_RD_START, ST_RD_DIV,
        ST_WH_START, ST_WH_DIV, ST_DONE
    } state_t;

    state_t               state_reg;
    mag_t                 an_reg, ad_reg, a_reg, b_reg, rn_reg, rd_reg;
    logic                 neg_reg;
    mag_t                 dvd_reg, dvs_reg, quo_reg;
    logic [MagWidth:0]    rem_reg;
    logic [CntWidth-1:0]  cnt_reg;

    logic                 out_valid_reg, out_status_reg, out_neg_reg;
    logic [31:0]          out_whole_reg, out_denom_reg;
    logic [30:0]          out_fnum_reg;

    mag_t                 an_next, ad_next;
    logic [MagWidth:0]    shift_rem;
    logic [MagWidth:0]    diff;
    logic                 div_last;

    assign an_next  = s_numer_in[DataWidth-1] ? mag_t'(-s_numer_in) : mag_t'(s_numer_in);
    assign ad_next  = s_denom_in[DataWidth-1] ? mag_t'(-s_denom_in) : mag_t'(s_denom_in);
    assign shift_rem = {rem_reg[MagWidth-1:0], dvd_reg[MagWidth-1]};
    assign diff      = shift_rem - {1'b0, dvs_reg};
    assign div_last  = (cnt_reg == CntWidth'(MagWidth - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        an_reg  <= an_next;
                        ad_reg  <= ad_next;
                        a_reg   <= an_next;
                        b_reg   <= ad_next;
                        neg_reg <= s_numer_in[DataWidth-1] ^ s_denom_in[DataWidth-1];
                        state_reg <= (ad_next == '0) ? ST_DONE : ST_GCD_STEP;
                    end
                end
                ST_GCD_STEP: begin
                    if (b_reg == '0) begin
                        state_reg <= ST_RN_START;
                    end else begin
                        state_reg <= ST_GCD_START;
                    end
                end
                ST_GCD_START, ST_RN_START, ST_RD_START, ST_WH_START: begin
                    case (state_reg)
                        ST_GCD_START: begin dvd_reg <= a_reg;  dvs_reg <= b_reg; end
                        ST_RN_START:  begin dvd_reg <= an_reg; dvs_reg <= a_reg; end
                        ST_RD_START:  begin dvd_reg <= ad_reg; dvs_reg <= a_reg; end
                        default:      begin dvd_reg <= rn_reg; dvs_reg <= rd_reg; end
                    endcase
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= state_t'(state_reg + 4'd1);
                end
                ST_GCD_DIV, ST_RN_DIV, ST_RD_DIV, ST_WH_DIV: begin
                    dvd_reg <= {dvd_reg[MagWidth-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (!diff[MagWidth]) begin
                        rem_reg <= diff;
                        quo_reg <= {quo_reg[MagWidth-2:0], 1'b1};
                    end else begin
                        rem_reg <= shift_rem;
                        quo_reg <= {quo_reg[MagWidth-2:0], 1'b0};
                    end
                    if (div_last) begin
                        case (state_reg)
                            ST_GCD_DIV: state_reg <= ST_GCD_STEP;
                            ST_RN_DIV:  state_reg <= ST_RD_START;
                            ST_RD_DIV:  state_reg <= ST_WH_START;
                            default:    state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (ad_reg == '0) begin
                            out_status_reg <= STATUS_ZERO_DEN;
                            out_neg_reg    <= 1'b0;
                            out_whole_reg  <= '0;
                            out_fnum_reg   <= '0;
                            out_denom_reg  <= 32'd1;
                        end else begin
                            out_status_reg <= STATUS_OK;
                            out_neg_reg    <= neg_reg && (rn_reg != '0);
                            out_whole_reg  <= 32'(quo_reg);
                            if (rem_reg == '0) begin
                                out_fnum_reg  <= '0;
                                out_denom_reg <= 32'd1;
                            end else begin
                                out_fnum_reg  <= 31'(rem_reg);
                                out_denom_reg <= 32'(rd_reg);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // capture results of finished divisions
            if (div_last) begin
                case (state_reg)
                    ST_GCD_DIV: begin
                        a_reg <= b_reg;
                        b_reg <= diff[MagWidth] ? shift_rem[MagWidth-1:0]
                                                : diff[MagWidth-1:0];
                    end
                    ST_RN_DIV: rn_reg <= {quo_reg[MagWidth-2:0], ~diff[MagWidth]};
                    ST_RD_DIV: rd_reg <= {quo_reg[MagWidth-2:0], ~diff[MagWidth]};
                    default: ;
                endcase
            end
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_is_negative = out_neg_reg;
    assign m_whole_part  = out_whole_reg;
    assign m_frac_numer  = out_fnum_reg;
    assign m_frac_denom  = out_denom_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_whole_part))
        else $error("result changed while stalled");
    a_denom_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frac_denom != 32'd0)
        else $error("zero denominator out");
    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_ZERO_DEN |-> m_frac_denom == 32'd1 && !m_is_negative)
        else $error("bad error result");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted while busy");
`endif

endmodule

// ===== verif/frmn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frmn_checker
// Watches both channels of the fraction reducer, computes the reduced mixed
// number for every input transfer and compares each output transfer with it.
// ----------------------------------------------------------------------------
module frmn_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  frmn_pkg::data_t    s_numer_in,
    input  frmn_pkg::data_t    s_denom_in,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_status,
    input  logic               m_is_negative,
    input  logic [31:0]        m_whole_part,
    input  logic [30:0]        m_frac_numer,
    input  logic [31:0]        m_frac_denom,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);
    import frmn_pkg::*;

    typedef struct packed {
        logic        status;
        logic        is_negative;
        logic [31:0] whole_part;
        logic [30:0] frac_numer;
        logic [31:0] frac_denom;
    } mixed_t;

    mixed_t mixed_q[$];

    function automatic mixed_t reduce_fraction(data_t numer, data_t denom);
        mixed_t      r;
        data_t       mn, md;
        logic [63:0] an, ad, a, b, t, g, rn, rd, rem;
        mn = numer[DataWidth-1] ? data_t'((~numer) + 1'b1) : numer;
        md = denom[DataWidth-1] ? data_t'((~denom) + 1'b1) : denom;
        an = 64'(mn);
        ad = 64'(md);
        r = '0;
        r.frac_denom = 32'd1;
        if (ad == 0) begin
            r.status = STATUS_ZERO_DEN;
            return r;
        end
        a = an;
        b = ad;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        g = a;
        rn = an / g;
        rd = ad / g;
        rem = rn % rd;
        r.status = STATUS_OK;
        r.is_negative = (rn != 0) && (numer[DataWidth-1] != denom[DataWidth-1]);
        r.whole_part = 32'(rn / rd);
        if (rem != 0) begin
            r.frac_numer = 31'(rem);
            r.frac_denom = 32'(rd);
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        mixed_t e;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
            result_count <= 0;
            pending_count <= 0;
            mixed_q.delete();
        end else begin
            if (s_valid && s_ready)
                mixed_q.push_back(reduce_fraction(s_numer_in, s_denom_in));
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (mixed_q.size() == 0) begin
                    $error("unexpected result transfer");
                    errs++;
                end else begin
                    e = mixed_q.pop_front();
                    if (e.status !== m_status) begin
                        $error("status exp %0d got %0d", e.status, m_status);
                        errs++;
                    end
                    if (e.is_negative !== m_is_negative) begin
                        $error("is_negative exp %0d got %0d", e.is_negative, m_is_negative);
                        errs++;
                    end
                    if (e.whole_part !== m_whole_part) begin
                        $error("whole_part exp %0d got %0d", e.whole_part, m_whole_part);
                        errs++;
                    end
                    if (e.frac_numer !== m_frac_numer) begin
                        $error("frac_numer exp %0d got %0d", e.frac_numer, m_frac_numer);
                        errs++;
                    end
                    if (e.frac_denom !== m_frac_denom) begin
                        $error("frac_denom exp %0d got %0d", e.frac_denom, m_frac_denom);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending_count <= mixed_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random fractions into the reducer under varying
// sender gaps and receiver stalls, then reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import frmn_pkg::*;

    localparam int StallLimit = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    data_t       s_numer_in = '0;
    data_t       s_denom_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status, m_is_negative;
    logic [31:0] m_whole_part, m_frac_denom;
    logic [30:0] m_frac_numer;
    int          fail_count, pending_count, result_count;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          quiet_cycles = 0;
    int          item_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    fraction_reduce_mixed_number DUT (.*);

    frmn_checker u_checker (.*);

    always @(posedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_fraction(data_t numer, data_t denom);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_numer_in <= numer;
        s_denom_in <= denom;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        item_count++;
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(5))
            0: return data_t'($urandom);
            1: return data_t'($urandom_range(40)) - 20;
            2: return data_t'($urandom_range(1000)) - 500;
            3: return {1'b1, 31'($urandom_range(3))};
            4: return {1'b0, {28{1'b1}}, 3'($urandom)};
            default: return data_t'($urandom_range(100000)) * (($urandom & 1) ? -1 : 1);
        endcase
    endfunction

    task automatic send_random(int n);
        data_t g, numer, denom;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                g = data_t'($urandom_range(1, 5000));
                numer = g * data_t'($urandom_range(200000)) * (($urandom & 1) ? -1 : 1);
                denom = g * data_t'($urandom_range(200000)) * (($urandom & 1) ? -1 : 1);
            end else begin
                numer = pick_value();
                denom = ($urandom_range(30) == 0) ? '0 : pick_value();
            end
            send_fraction(numer, denom);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_fraction(32'sd7, 32'sd0);
        send_fraction(32'h8000_0000, 32'sd0);
        send_fraction(32'sd0, 32'sd5);
        send_fraction(32'sd0, -32'sd5);
        send_fraction(32'sd6, 32'sd4);
        send_fraction(-32'sd6, 32'sd4);
        send_fraction(32'sd6, -32'sd4);
        send_fraction(-32'sd6, -32'sd4);
        send_fraction(32'sd12, 32'sd4);
        send_fraction(32'sd3, 32'sd7);
        send_fraction(32'h8000_0000, 32'sd1);
        send_fraction(32'h8000_0000, -32'sd1);
        send_fraction(32'h8000_0000, 32'h8000_0000);
        send_fraction(32'sd1, 32'h8000_0000);
        send_fraction(32'h7fff_ffff, 32'h8000_0000);
        send_fraction(32'h8000_0000, 32'h7fff_ffff);
        send_fraction(32'h7fff_ffff, 32'sd2);
        send_fraction(32'sd1, 32'h7fff_ffff);
        send_fraction(32'hffff_ffff, 32'hffff_ffff);
        send_fraction(32'sd1134903170, 32'sd701408733);

        send_random(500);
        send_idle_pct = 67;
        send_random(450);
        send_idle_pct = 0;
        recv_stall_pct = 67;
        send_random(450);
        send_idle_pct = 27;
        recv_stall_pct = 27;
        send_random(300);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_random(30);
        join
        send_random(200);
        s_valid <= 1'b0;

        while (pending_count != 0 || result_count != item_count)
            @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Covered %0d fractions and %0d results, zero and extreme denominators,",
                 item_count, result_count);
        $display("with sender gaps, receiver stalls and a long output hold-off.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
